/* rtl/merge_bounding_spheres_unit_macros.svh */
// Assertion macros for the sphere merge unit.
// Used by merge_bounding_spheres_unit; expects clk and rst_n in scope.
`ifndef MERGE_BOUNDING_SPHERES_UNIT_MACROS_SVH
`define MERGE_BOUNDING_SPHERES_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MBS_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define MBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define MBS_ASSERT_IMPLIES(lbl, ante, cons)
`define MBS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/mbs_pkg.sv */
// Shared constants and types for the sphere merge unit.
// No dependencies.
package mbs_pkg;
  parameter int COORD_BITS_DEF = 32;
  typedef logic [2:0] axis_mask_t;
endpackage

/* rtl/merge_bounding_spheres_unit.sv */
// Sphere merge unit: returns the smallest sphere enclosing two input spheres.
// Depends on mbs_pkg, mbs_mul, mbs_div and the assertion macro header.
//
// Usage: an item on the input channel is a pair of spheres (centres and
// radii in fixed point); each accepted item gives exactly one result item
// on the output channel, in order. Both channels use valid and stall; an
// item moves at a clock edge with valid high and stall low.
// Throughput is one item per cycle while the output is not stalled. Most
// of the pipeline is the bit-per-stage square root (COORD_BITS+2
// stages) and the bit-per-stage dividers (COORD_BITS+1 stages).
// When the contained sphere case applies, the larger input sphere is
// passed through; otherwise the centre and radius are computed and an
// oversized radius is clamped with the saturation flag raised.
// Reset clears all valid bits; payload registers are not reset.
// While a result is waiting and the receiver stalls, the whole pipeline
// holds and in_stall is raised; nothing is dropped or repeated.
`include "merge_bounding_spheres_unit_macros.svh"
module merge_bounding_spheres_unit #(
  parameter int COORD_BITS = mbs_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_a_center_x,
  input  logic signed [COORD_BITS-1:0] in_a_center_y,
  input  logic signed [COORD_BITS-1:0] in_a_center_z,
  input  logic        [COORD_BITS-2:0] in_a_radius,
  input  logic signed [COORD_BITS-1:0] in_b_center_x,
  input  logic signed [COORD_BITS-1:0] in_b_center_y,
  input  logic signed [COORD_BITS-1:0] in_b_center_z,
  input  logic        [COORD_BITS-2:0] in_b_radius,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] out_merged_x,
  output logic signed [COORD_BITS-1:0] out_merged_y,
  output logic signed [COORD_BITS-1:0] out_merged_z,
  output logic        [COORD_BITS-2:0] out_merged_radius,
  output logic                         out_radius_saturated
);
  import mbs_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int DMW  = C + 1;
  localparam int LSQW = 2 * C + 3;
  localparam int RB   = C + 2;
  localparam int RW   = RB + 3;
  localparam int NW   = 2 * RB;
  localparam int PW   = C + 2;
  localparam int XW   = 2 * PW;
  localparam int QB   = C + 1;
  localparam int DW   = C + 2;
  localparam logic [C-2:0] RAD_MAX = '1;

  typedef struct packed {
    logic [2:0][C-1:0]   ca;
    logic [2:0][C-1:0]   cb;
    logic [2:0][DMW-1:0] dmag;
    axis_mask_t          dneg;
    logic [C-2:0]        ra;
    logic [C-2:0]        rb;
    logic signed [C-1:0] rd;
    logic                contain;
    logic [RB-1:0]       len;
    logic [PW-1:0]       num_t;
    logic [C-2:0]        rad;
    logic                sat;
  } side_t;

  logic adv;
  logic out_valid_r;

  // The whole pipeline moves together unless a waiting result is stalled.
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // Stage 1: centre differences and radius difference.
  logic [2:0][C-1:0] ca_in, cb_in;
  side_t             s1_nxt, s1_side_r;
  logic [C-1:0]      rdmag_nxt, s1_rdmag_r;
  logic              s1_v_r;

  assign ca_in[0] = in_a_center_x;
  assign ca_in[1] = in_a_center_y;
  assign ca_in[2] = in_a_center_z;
  assign cb_in[0] = in_b_center_x;
  assign cb_in[1] = in_b_center_y;
  assign cb_in[2] = in_b_center_z;

  always_comb begin
    logic [C:0] dfull;
    s1_nxt    = '0;
    s1_nxt.ca = ca_in;
    s1_nxt.cb = cb_in;
    s1_nxt.ra = in_a_radius;
    s1_nxt.rb = in_b_radius;
    for (int k = 0; k < 3; k++) begin
      dfull          = {ca_in[k][C-1], ca_in[k]} - {cb_in[k][C-1], cb_in[k]};
      s1_nxt.dneg[k] = dfull[C];
      s1_nxt.dmag[k] = dfull[C] ? (~dfull + 1'b1) : dfull;
    end
    s1_nxt.rd = $signed({1'b0, in_a_radius}) - $signed({1'b0, in_b_radius});
    rdmag_nxt = s1_nxt.rd[C-1] ? (~s1_nxt.rd + 1'b1) : s1_nxt.rd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side_r  <= s1_nxt;
      s1_rdmag_r <= rdmag_nxt;
    end
  end

  // Stages 2 and 3: squares of the differences.
  logic [2*DMW-1:0] sq_p [3];
  logic [2*DMW-1:0] rdsq_p;
  side_t            s2_side_r, s3_side_r;
  logic             s2_v_r, s3_v_r;

  for (genvar k = 0; k < 3; k++) begin : g_sq
    mbs_mul #(.W(DMW)) u_sq (
      .clk (clk),
      .en  (adv),
      .a   (s1_side_r.dmag[k]),
      .b   (s1_side_r.dmag[k]),
      .p   (sq_p[k])
    );
  end

  mbs_mul #(.W(DMW)) u_rdsq (
    .clk (clk),
    .en  (adv),
    .a   (DMW'(s1_rdmag_r)),
    .b   (DMW'(s1_rdmag_r)),
    .p   (rdsq_p)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_side_r <= s1_side_r;
      s3_side_r <= s2_side_r;
    end
  end

  // Stage 4: squared distance and the containment test.
  logic [LSQW-1:0] lsq_nxt, s4_lsq_r;
  side_t           s4_nxt, s4_side_r;
  logic            s4_v_r;

  always_comb begin
    lsq_nxt        = LSQW'(sq_p[0]) + LSQW'(sq_p[1]) + LSQW'(sq_p[2]);
    s4_nxt         = s3_side_r;
    s4_nxt.contain = lsq_nxt <= LSQW'(rdsq_p);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_lsq_r  <= lsq_nxt;
      s4_side_r <= s4_nxt;
    end
  end

  // Square root: one result bit per stage, restoring digit recurrence.
  logic [RB-1:0] sq_v_r;
  side_t         sq_side_r [RB];
  logic [RW-1:0] sq_rem_r  [RB];
  logic [RB-1:0] sq_root_r [RB];
  logic [NW-1:0] sq_n_r    [RB];

  for (genvar j = 0; j < RB; j++) begin : g_root
    logic [RW-1:0] rem_in, cur, trial;
    logic [RB-1:0] root_in;
    logic [NW-1:0] n_in;
    logic          v_in;
    side_t         side_in;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = NW'(s4_lsq_r);
      assign v_in    = s4_v_r;
      assign side_in = s4_side_r;
    end else begin : g_next
      assign rem_in  = sq_rem_r[j-1];
      assign root_in = sq_root_r[j-1];
      assign n_in    = sq_n_r[j-1];
      assign v_in    = sq_v_r[j-1];
      assign side_in = sq_side_r[j-1];
    end

    assign cur   = {rem_in[RW-3:0], n_in[NW-1 -: 2]};
    assign trial = RW'({root_in, 2'b01});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[j] <= 1'b0;
      end else if (adv) begin
        sq_v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (cur >= trial) begin
          sq_rem_r[j]  <= cur - trial;
          sq_root_r[j] <= {root_in[RB-2:0], 1'b1};
        end else begin
          sq_rem_r[j]  <= cur;
          sq_root_r[j] <= {root_in[RB-2:0], 1'b0};
        end
        sq_n_r[j]    <= n_in << 2;
        sq_side_r[j] <= side_in;
      end
    end
  end

  // Stage 5: round the root up, form the weight numerator and the radius.
  side_t         s5_nxt, s5_side_r;
  logic          s5_v_r;

  always_comb begin
    logic [RB-1:0]  len;
    logic [C+3:0]   numt_w;
    logic [C+2:0]   radsum;
    logic [C+1:0]   rad_full;
    s5_nxt       = sq_side_r[RB-1];
    len          = sq_root_r[RB-1] + RB'(sq_rem_r[RB-1] != '0);
    numt_w       = {2'b00, len} + {{4{s5_nxt.rd[C-1]}}, s5_nxt.rd};
    radsum       = (C+3)'(len) + (C+3)'(s5_nxt.ra) + (C+3)'(s5_nxt.rb) + (C+3)'(1);
    rad_full     = radsum[C+2:1];
    s5_nxt.len   = len;
    s5_nxt.num_t = numt_w[PW-1:0];
    s5_nxt.sat   = |rad_full[C+1:C-1];
    s5_nxt.rad   = s5_nxt.sat ? RAD_MAX : rad_full[C-2:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (adv) begin
      s5_v_r <= sq_v_r[RB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_side_r <= s5_nxt;
    end
  end

  // Stages 6 and 7: offset numerators |d| * (L + rd).
  logic [XW-1:0] prod_p [3];
  side_t         s6_side_r, s7_side_r;
  logic          s6_v_r, s7_v_r;

  for (genvar k = 0; k < 3; k++) begin : g_prod
    mbs_mul #(.W(PW)) u_prod (
      .clk (clk),
      .en  (adv),
      .a   (PW'(s5_side_r.dmag[k])),
      .b   (s5_side_r.num_t),
      .p   (prod_p[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
    end else if (adv) begin
      s6_v_r <= s5_v_r;
      s7_v_r <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_side_r <= s5_side_r;
      s7_side_r <= s6_side_r;
    end
  end

  // Stage 8: add half the divisor for round-to-nearest.
  logic [XW-2:0] s8_dvd_r [3];
  logic [DW-1:0] s8_dvs_r;
  side_t         s8_side_r;
  logic          s8_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_v_r <= 1'b0;
    end else if (adv) begin
      s8_v_r <= s7_v_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [XW-1:0] dvd;
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        dvd         = prod_p[k] + XW'(s7_side_r.len);
        s8_dvd_r[k] <= dvd[XW-2:0];
      end
      s8_dvs_r  <= {s7_side_r.len[C:0], 1'b0};
      s8_side_r <= s7_side_r;
    end
  end

  // Divider stages, one per quotient bit, with the item data alongside.
  logic [QB-1:0] dv_q [3];
  logic [QB-1:0] dv_v_r;
  side_t         dv_side_r [QB];

  for (genvar k = 0; k < 3; k++) begin : g_div
    mbs_div #(.QB(QB), .DW(DW)) u_div (
      .clk      (clk),
      .en       (adv),
      .dividend (s8_dvd_r[k]),
      .divisor  (s8_dvs_r),
      .quotient (dv_q[k])
    );
  end

  for (genvar i = 0; i < QB; i++) begin : g_dv_side
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[i] <= 1'b0;
      end else if (adv) begin
        dv_v_r[i] <= (i == 0) ? s8_v_r : dv_v_r[(i == 0) ? 0 : i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_side_r[i] <= (i == 0) ? s8_side_r : dv_side_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  // Output stage: apply the signed offsets or pass the larger sphere through.
  side_t             fin;
  logic [2:0][C-1:0] ctr_nxt;
  logic [C-2:0]      rad_nxt;
  logic              sat_nxt;

  assign fin = dv_side_r[QB-1];

  always_comb begin
    logic [C+1:0] qs, offs, sum;
    for (int k = 0; k < 3; k++) begin
      qs   = {1'b0, dv_q[k]};
      offs = fin.dneg[k] ? (~qs + 1'b1) : qs;
      sum  = {{2{fin.cb[k][C-1]}}, fin.cb[k]} + offs;
      if (fin.contain) begin
        ctr_nxt[k] = fin.rd[C-1] ? fin.cb[k] : fin.ca[k];
      end else begin
        ctr_nxt[k] = sum[C-1:0];
      end
    end
    if (fin.contain) begin
      rad_nxt = fin.rd[C-1] ? fin.rb : fin.ra;
      sat_nxt = 1'b0;
    end else begin
      rad_nxt = fin.rad;
      sat_nxt = fin.sat;
    end
  end

  logic [2:0][C-1:0] out_ctr_r;
  logic [C-2:0]      out_rad_r;
  logic              out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_v_r[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ctr_r <= ctr_nxt;
      out_rad_r <= rad_nxt;
      out_sat_r <= sat_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_merged_x         = out_ctr_r[0];
  assign out_merged_y         = out_ctr_r[1];
  assign out_merged_z         = out_ctr_r[2];
  assign out_merged_radius    = out_rad_r;
  assign out_radius_saturated = out_sat_r;

  // A rounded offset never exceeds the centre distance on its axis.
  `MBS_ASSERT_IMPLIES(a_offset_bound, dv_v_r[QB-1] && !fin.contain, (dv_q[0] <= fin.dmag[0]) && (dv_q[1] <= fin.dmag[1]) && (dv_q[2] <= fin.dmag[2]))
  // A stall freezes the valid bits deep inside the pipeline.
  `MBS_ASSERT_NEXT(a_hold_on_stall, in_stall, $stable(dv_v_r) && $stable(s4_v_r) && $stable(sq_v_r))
  // A saturated result carries the largest radius.
  `MBS_ASSERT_IMPLIES(a_sat_max, out_valid && out_radius_saturated, out_merged_radius == RAD_MAX)
endmodule

/* rtl/mbs_mul.sv */
// Two-stage unsigned multiplier built from four half-width partial products.
// No dependencies.
module mbs_mul #(
  parameter int W = 33
) (
  input  logic           clk,
  input  logic           en,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [2*W-1:0] p
);
  localparam int H = (W + 1) / 2;
  localparam int L = W - H;

  logic [H-1:0]     al, bl;
  logic [L-1:0]     ah, bh;
  logic [2*H-1:0]   p00_r;
  logic [H+L-1:0]   p01_r, p10_r;
  logic [2*L-1:0]   p11_r;
  logic [2*W-1:0]   p_r;

  assign al = a[H-1:0];
  assign ah = a[W-1:H];
  assign bl = b[H-1:0];
  assign bh = b[W-1:H];

  // First stage: the partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      p00_r <= (2*H)'(al) * (2*H)'(bl);
      p01_r <= (H+L)'(al) * (H+L)'(bh);
      p10_r <= (H+L)'(ah) * (H+L)'(bl);
      p11_r <= (2*L)'(ah) * (2*L)'(bh);
    end
  end

  // Second stage: weighted sum of the partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= (2*W)'(p00_r) + ((2*W)'(p01_r) << H) + ((2*W)'(p10_r) << H)
             + ((2*W)'(p11_r) << (2*H));
    end
  end

  assign p = p_r;
endmodule

/* rtl/mbs_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// The quotient must fit in QB bits. No dependencies.
module mbs_div #(
  parameter int QB = 33,
  parameter int DW = 34
) (
  input  logic             clk,
  input  logic             en,
  input  logic [QB+DW-1:0] dividend,
  input  logic [DW-1:0]    divisor,
  output logic [QB-1:0]    quotient
);
  logic [DW-1:0] rem_r [QB];
  logic [DW-1:0] dvs_r [QB];
  logic [QB-1:0] low_r [QB];
  logic [QB-1:0] q_r   [QB];

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [DW-1:0] rem_in, dvs_in;
    logic [QB-1:0] low_in, q_in;
    logic [DW:0]   cur, diff;
    logic          ge;

    // Each stage takes the previous stage's partial remainder.
    if (i == 0) begin : g_first
      assign rem_in = dividend[QB+DW-1:QB];
      assign low_in = dividend[QB-1:0];
      assign dvs_in = divisor;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign low_in = low_r[i-1];
      assign dvs_in = dvs_r[i-1];
      assign q_in   = q_r[i-1];
    end

    assign cur  = {rem_in, low_in[QB-1]};
    assign diff = cur - {1'b0, dvs_in};
    assign ge   = cur >= {1'b0, dvs_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? diff[DW-1:0] : cur[DW-1:0];
        q_r[i]   <= {q_in[QB-2:0], ge};
        low_r[i] <= low_in << 1;
        dvs_r[i] <= dvs_in;
      end
    end
  end

  assign quotient = q_r[QB-1];
endmodule
